[rtl/sjfq_pkg.sv]
package sjfq_pkg;

  localparam int DEPTH      = 16;
  localparam int ID_WIDTH   = 16;
  localparam int TIME_WIDTH = 16;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;

  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_SORT = 2'd1;
  localparam logic [OP_W-1:0] OP_POP       = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic              load;      // capture the incoming item
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              ins_step;  // sorted insert ripple step on returned entry
    logic              pop_step;  // pop shift step on returned entry
    logic              tail_wr;   // write pending entry at index cnt
    logic              cnt_inc;
    logic              cnt_dec;
    logic              fin;       // load the result register
    logic [STAT_W-1:0] status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [CW-1:0] cnt;
    logic          out_free;
  } sts_t;

endpackage

[rtl/sjf_ready_queue_core.sv]
// channel | handshake                | fields
// input   | in_valid_i, in_stall_o   | opcode_i, proc_id_i, burst_time_i
// output  | out_valid_o, out_stall_i | status_o, out_id_o, out_time_o, occupancy_o
//
// One item at a time. Full push, empty pop and no-op go from transfer straight to the
// result state; tail push first writes the tail slot. Pop walks the N entries held, one
// entry per cycle; a sorted push walks them too, then writes the tail slot.
// Reset is asynchronous, active low; it empties the queue, entry memory is not cleared.
// A stalled result sits in the output register; the next item is taken meanwhile.
module sjf_ready_queue_core import sjfq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       opcode_i,
  input  logic [ID_WIDTH-1:0]   proc_id_i,
  input  logic [TIME_WIDTH-1:0] burst_time_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STAT_W-1:0]     status_o,
  output logic [ID_WIDTH-1:0]   out_id_o,
  output logic [TIME_WIDTH-1:0] out_time_o,
  output logic [CW-1:0]         occupancy_o
);

  cmd_t cmd;
  sts_t sts;

  sjfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sjfq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .proc_id_i    (proc_id_i),
    .burst_time_i (burst_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_id_o     (out_id_o),
    .out_time_o   (out_time_o),
    .occupancy_o  (occupancy_o)
  );

endmodule

[rtl/sjfq_ctrl.sv]
module sjfq_ctrl import sjfq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [OP_W-1:0] opcode_i,
  input  sts_t            sts_i,
  output cmd_t            cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic              pop_q, pop_d;
  logic [STAT_W-1:0] st_q, st_d;
  logic [CW-1:0]     nxt_q, nxt_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    pop_d   = pop_q;
    st_d    = st_q;
    nxt_d   = nxt_q;
    cmd_o   = '0;
    cmd_o.status = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d  = ST_OK;
          pop_d = (opcode_i == OP_POP);
          nxt_d = CW'(1);
          if (opcode_i inside {OP_PUSH_TAIL, OP_PUSH_SORT}) begin
            if (sts_i.cnt == CW'(DEPTH)) begin
              st_d    = ST_FULL;
              state_d = S_FIN;
            end else if (opcode_i == OP_PUSH_TAIL || sts_i.cnt == '0) begin
              state_d = S_TAIL;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = '0;
              state_d       = S_SCAN;
            end
          end else if (opcode_i == OP_POP) begin
            if (sts_i.cnt == '0) begin
              st_d    = ST_EMPTY;
              state_d = S_FIN;
            end else begin
              cmd_o.rd_en   = 1'b1;
              cmd_o.rd_addr = '0;
              state_d       = S_SCAN;
            end
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        // one entry returns per cycle; next read overlaps the current write
        cmd_o.ins_step = !pop_q;
        cmd_o.pop_step = pop_q;
        if (nxt_q < sts_i.cnt) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = nxt_q[AW-1:0];
          nxt_d         = nxt_q + CW'(1);
        end else if (pop_q) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FIN;
        end else begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd_o.tail_wr = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pop_q   <= 1'b0;
      st_q    <= ST_OK;
      nxt_q   <= '0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
      st_q    <= st_d;
      nxt_q   <= nxt_d;
    end
  end

endmodule

[rtl/sjfq_datapath.sv]
module sjfq_datapath import sjfq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [ID_WIDTH-1:0]   proc_id_i,
  input  logic [TIME_WIDTH-1:0] burst_time_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STAT_W-1:0]     status_o,
  output logic [ID_WIDTH-1:0]   out_id_o,
  output logic [TIME_WIDTH-1:0] out_time_o,
  output logic [CW-1:0]         occupancy_o
);

  logic [ID_WIDTH-1:0]   mem_id [DEPTH];
  logic [TIME_WIDTH-1:0] mem_tm [DEPTH];

  logic [ID_WIDTH-1:0]   rd_id_q, new_id_q, carry_id_q, pop_id_q, out_id_q;
  logic [TIME_WIDTH-1:0] rd_tm_q, new_tm_q, carry_tm_q, pop_tm_q, out_tm_q;
  logic [AW-1:0]         rd_addr_q;
  logic                  ins_q;
  logic [CW-1:0]         cnt_q;
  logic                  out_valid_q;
  logic [STAT_W-1:0]     out_st_q;
  logic [CW-1:0]         out_occ_q;

  logic                  less;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ID_WIDTH-1:0]   wr_id;
  logic [TIME_WIDTH-1:0] wr_tm;

  // returned entry stays ahead of the new one
  assign less = (rd_tm_q < new_tm_q) || ((rd_tm_q == new_tm_q) && (rd_id_q < new_id_q));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_id   = '0;
    wr_tm   = '0;
    if (cmd_i.tail_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[AW-1:0];
      wr_id   = ins_q ? carry_id_q : new_id_q;
      wr_tm   = ins_q ? carry_tm_q : new_tm_q;
    end else if (cmd_i.ins_step) begin
      wr_addr = rd_addr_q;
      if (ins_q) begin
        wr_en = 1'b1;
        wr_id = carry_id_q;
        wr_tm = carry_tm_q;
      end else if (!less) begin
        wr_en = 1'b1;
        wr_id = new_id_q;
        wr_tm = new_tm_q;
      end
    end else if (cmd_i.pop_step && (rd_addr_q != '0)) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_q - AW'(1);
      wr_id   = rd_id_q;
      wr_tm   = rd_tm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_id[wr_addr] <= wr_id;
      mem_tm[wr_addr] <= wr_tm;
    end
    if (cmd_i.rd_en) begin
      rd_id_q   <= mem_id[cmd_i.rd_addr];
      rd_tm_q   <= mem_tm[cmd_i.rd_addr];
      rd_addr_q <= cmd_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_id_q <= proc_id_i;
      new_tm_q <= burst_time_i;
      pop_id_q <= '0;
      pop_tm_q <= '0;
    end
    if (cmd_i.ins_step) begin
      carry_id_q <= rd_id_q;
      carry_tm_q <= rd_tm_q;
    end
    if (cmd_i.pop_step && (rd_addr_q == '0)) begin
      pop_id_q <= rd_id_q;
      pop_tm_q <= rd_tm_q;
    end
    if (cmd_i.fin) begin
      out_st_q  <= cmd_i.status;
      out_id_q  <= pop_id_q;
      out_tm_q  <= pop_tm_q;
      out_occ_q <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ins_q <= 1'b0;
      end else if (cmd_i.ins_step && !less) begin
        ins_q <= 1'b1;
      end
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.cnt      = cnt_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign out_id_o    = out_id_q;
  assign out_time_o  = out_tm_q;
  assign occupancy_o = out_occ_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_inc |-> cnt_q < CW'(DEPTH))
    else $error("push committed on full queue");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_dec |-> cnt_q != '0)
    else $error("pop committed on empty queue");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> CW'(cmd_i.rd_addr) < cnt_q)
    else $error("read of entry beyond count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin |-> !(out_valid_q && out_stall_i))
    else $error("result register overwritten while stalled");

endmodule

[verif/tb_top.sv]
module tb_top;
  import sjfq_pkg::*;

  // opcode 3 is not defined by the block; it must act as a no-op
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int DRAIN_TAIL = DEPTH + 8;

  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [ID_WIDTH-1:0]   pid;
    logic [TIME_WIDTH-1:0] burst;
    logic [CW-1:0]         occ;
  } sched_reply_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [OP_W-1:0]       opcode_i = OP_NONE;
  logic [ID_WIDTH-1:0]   proc_id_i = '0;
  logic [TIME_WIDTH-1:0] burst_time_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [STAT_W-1:0]     status_o;
  logic [ID_WIDTH-1:0]   out_id_o;
  logic [TIME_WIDTH-1:0] out_time_o;
  logic [CW-1:0]         occupancy_o;

  // shadow copy of the ready queue, head at index 0
  logic [ID_WIDTH-1:0]   shadow_ids[DEPTH];
  logic [TIME_WIDTH-1:0] shadow_bursts[DEPTH];
  int                    shadow_cnt;

  sched_reply_t sched_replies_due[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_left;
  int n_errors;
  int n_items;
  int n_replies;
  int n_full_drops;
  int n_empty_pops;
  int n_good_pops;
  int n_sorted;
  int peak_occ;

  sjf_ready_queue_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .proc_id_i    (proc_id_i),
    .burst_time_i (burst_time_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_id_o     (out_id_o),
    .out_time_o   (out_time_o),
    .occupancy_o  (occupancy_o)
  );

  always #2 clk_i = ~clk_i;

  // apply one accepted operation to the shadow queue and queue up its reply
  task automatic sched_queue_apply(input logic [OP_W-1:0] op,
                                   input logic [ID_WIDTH-1:0] pid,
                                   input logic [TIME_WIDTH-1:0] burst);
    sched_reply_t r;
    int slot;
    r = '0;
    r.status = ST_OK;
    if (op == OP_PUSH_TAIL || op == OP_PUSH_SORT) begin
      if (shadow_cnt >= DEPTH) begin
        r.status = ST_FULL;
        n_full_drops++;
      end else begin
        slot = shadow_cnt;
        if (op == OP_PUSH_SORT) begin
          slot = 0;
          while (slot < shadow_cnt && (shadow_bursts[slot] < burst ||
                 (shadow_bursts[slot] == burst && shadow_ids[slot] < pid)))
            slot++;
          n_sorted++;
        end
        for (int i = shadow_cnt; i > slot; i--) begin
          shadow_ids[i]    = shadow_ids[i-1];
          shadow_bursts[i] = shadow_bursts[i-1];
        end
        shadow_ids[slot]    = pid;
        shadow_bursts[slot] = burst;
        shadow_cnt++;
      end
    end else if (op == OP_POP) begin
      if (shadow_cnt == 0) begin
        r.status = ST_EMPTY;
        n_empty_pops++;
      end else begin
        r.pid   = shadow_ids[0];
        r.burst = shadow_bursts[0];
        for (int i = 1; i < shadow_cnt; i++) begin
          shadow_ids[i-1]    = shadow_ids[i];
          shadow_bursts[i-1] = shadow_bursts[i];
        end
        shadow_cnt--;
        n_good_pops++;
      end
    end
    r.occ = CW'(shadow_cnt);
    if (shadow_cnt > peak_occ) peak_occ = shadow_cnt;
    sched_replies_due.push_back(r);
  endtask

  // offer one item; returns at the edge where the transfer happened, valid left high
  task automatic send_op(input logic [OP_W-1:0] op,
                         input logic [ID_WIDTH-1:0] pid,
                         input logic [TIME_WIDTH-1:0] burst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    proc_id_i    <= pid;
    burst_time_i <= burst;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    sched_queue_apply(op, pid, burst);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sched_replies_due.size() != 0 || hold_left != 0);
  endtask

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
  endtask

  // receiver: random stall, plus a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sched_reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_replies++;
      if (sched_replies_due.size() == 0) begin
        $error("result with no pending operation: status %0d id %0h time %0h occ %0d",
               status_o, out_id_o, out_time_o, occupancy_o);
        n_errors++;
      end else begin
        want = sched_replies_due.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          n_errors++;
        end
        if (out_id_o !== want.pid) begin
          $error("out_id: expected %0h, got %0h", want.pid, out_id_o);
          n_errors++;
        end
        if (out_time_o !== want.burst) begin
          $error("out_time: expected %0h, got %0h", want.burst, out_time_o);
          n_errors++;
        end
        if (occupancy_o !== want.occ) begin
          $error("occupancy: expected %0d, got %0d", want.occ, occupancy_o);
          n_errors++;
        end
      end
    end
  end

  // empty and full corners, ties in the sort order, field extremes
  task automatic test_directed();
    send_op(OP_POP, 16'hFFFF, 16'hFFFF);          // pop on empty queue
    send_op(OP_NONE, 16'h1234, 16'h5678);
    send_op(OP_PUSH_TAIL, 16'h0000, 16'h0000);
    send_op(OP_PUSH_TAIL, 16'hFFFF, 16'hFFFF);
    send_op(OP_PUSH_SORT, 16'h0010, 16'h0100);
    send_op(OP_PUSH_SORT, 16'h0010, 16'h0100);    // equal time and id: goes in front
    send_op(OP_PUSH_SORT, 16'h0008, 16'h0100);    // equal time, smaller id
    send_op(OP_PUSH_SORT, 16'h0020, 16'h0100);    // equal time, larger id
    send_op(OP_PUSH_SORT, 16'hFFFF, 16'h0000);
    send_op(OP_PUSH_SORT, 16'h0000, 16'hFFFF);
    send_op(OP_PUSH_SORT, 16'hAAAA, 16'h5555);
    send_op(OP_PUSH_SORT, 16'h5555, 16'hAAAA);
    send_op(OP_PUSH_TAIL, 16'h0001, 16'h0001);
    for (int i = 0; i < 5; i++)
      send_op(OP_PUSH_SORT, ID_WIDTH'($urandom), TIME_WIDTH'($urandom));
    send_op(OP_PUSH_TAIL, 16'h7777, 16'h7777);    // queue already full, dropped
    send_op(OP_PUSH_SORT, 16'h0000, 16'h0000);
    send_op(OP_NONE, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 3; i++)
      send_op(OP_POP, 16'h0000, 16'h0000);
    wait_drain();
  endtask

  // mostly push/pop traffic with a drifting mix so the queue swings between empty and full
  task automatic test_random_traffic(input int count);
    int push_pct;
    int pick;
    logic [OP_W-1:0] op;
    logic [ID_WIDTH-1:0] pid;
    logic [TIME_WIDTH-1:0] burst;
    push_pct = 50;
    for (int k = 0; k < count; k++) begin
      if (k % 16 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 20;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) op = OP_NONE;
      else if (pick < 4 + push_pct) op = $urandom_range(0, 1) ? OP_PUSH_SORT : OP_PUSH_TAIL;
      else op = OP_POP;
      // narrow keys half the time so ties in time and id are common
      if ($urandom_range(0, 1)) begin
        pid   = ID_WIDTH'($urandom);
        burst = TIME_WIDTH'($urandom);
      end else begin
        pid   = ID_WIDTH'($urandom_range(0, 3));
        burst = TIME_WIDTH'($urandom_range(0, 7));
      end
      send_op(op, pid, burst);
    end
    wait_drain();
  endtask

  // receiver holds off long enough for the block to back up and stall its input
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_req = 300;
    for (int k = 0; k < 20; k++)
      send_op((k % 3 == 2) ? OP_POP : OP_PUSH_SORT, ID_WIDTH'($urandom),
              TIME_WIDTH'($urandom_range(0, 15)));
    wait_drain();
  endtask

  initial begin
    set_idling(12, 87);
    hold_req  = 0;
    hold_left = 0;
    shadow_cnt = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(160);
    set_idling(87, 12);
    test_random_traffic(160);
    set_idling(0, 0);
    test_random_traffic(160);
    test_backpressure();

    repeat (DRAIN_TAIL) @(posedge clk_i);
    $display("Ran %0d operations, %0d results (%0d sorted pushes, %0d good pops).",
             n_items, n_replies, n_sorted, n_good_pops);
    $display("Dropped pushes on full: %0d, pops on empty: %0d, peak occupancy %0d.",
             n_full_drops, n_empty_pops, peak_occ);
    if (n_errors == 0 && sched_replies_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results still pending.", sched_replies_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
rtl/sjfq_pkg.sv
rtl/sjfq_ctrl.sv
rtl/sjfq_datapath.sv
rtl/sjf_ready_queue_core.sv
verif/tb_top.sv
